// ----- rtl/ata_pio_command_sequencer_core_macros.svh -----
// ----------------------------------------------------------------------------
// ata pio command sequencer assertion macros
// concurrent checks clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ATA_PIO_COMMAND_SEQUENCER_CORE_MACROS_SVH
`define ATA_PIO_COMMAND_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication
`define APCS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define APCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/apcs_pkg.sv -----
// ----------------------------------------------------------------------------
// apcs_pkg
// types and constants shared by the ata pio command sequencer modules
// ----------------------------------------------------------------------------
`default_nettype none

package apcs_pkg;

	localparam int ADDR_W = 48;
	localparam int SUM_W  = ADDR_W + 1;

	// configuration register indexes
	localparam logic [1:0] CFG_CAPACITY = 2'd0;
	localparam logic [1:0] CFG_LBA48    = 2'd1;
	localparam logic [1:0] CFG_DRIVE    = 2'd2;
	localparam logic [1:0] CFG_IS_DISK  = 2'd3;

	// result kinds
	localparam logic [2:0] KIND_WRITE  = 3'd0;
	localparam logic [2:0] KIND_DONE   = 3'd1;
	localparam logic [2:0] KIND_REJECT = 3'd2;
	localparam logic [2:0] KIND_FAIL   = 3'd3;
	localparam logic [2:0] KIND_BAD    = 3'd4;

	// task-file register selects
	localparam logic [3:0] REG_NONE  = 4'd0;
	localparam logic [3:0] REG_COUNT = 4'd2;
	localparam logic [3:0] REG_LBA0  = 4'd3;
	localparam logic [3:0] REG_LBA1  = 4'd4;
	localparam logic [3:0] REG_LBA2  = 4'd5;
	localparam logic [3:0] REG_DRIVE = 4'd6;
	localparam logic [3:0] REG_CMD   = 4'd7;
	localparam logic [3:0] REG_CTRL  = 4'd8;

	localparam logic [7:0] CTRL_NO_IRQ  = 8'h02;
	localparam logic [7:0] DRIVE_LBA48  = 8'h40;
	localparam logic [7:0] DRIVE_LBA28  = 8'hE0;
	localparam logic [7:0] DRIVE_SLAVE  = 8'h10;
	localparam logic [7:0] CMD_RD28     = 8'h20;
	localparam logic [7:0] CMD_RD48     = 8'h24;
	localparam logic [7:0] CMD_WR28     = 8'h30;
	localparam logic [7:0] CMD_WR48     = 8'h34;
	localparam logic [7:0] ST_ERR       = 8'h01;
	localparam logic [7:0] ST_DF        = 8'h20;
	localparam logic [7:0] ST_FLOAT     = 8'hFF;

	localparam logic [27:0] LIMIT28 = 28'h0FFFFFFF;
	localparam logic [15:0] MAX28   = 16'd255;
	localparam logic [15:0] MAX48   = 16'd65535;

	// beat positions of the last write of a chunk
	localparam logic [3:0] LAST_BEAT28 = 4'd6;
	localparam logic [3:0] LAST_BEAT48 = 4'd10;

	typedef struct packed {
		logic [ADDR_W-1:0] capacity;
		logic              lba48_ok;
		logic              unit;
		logic              is_disk;
	} apcs_cfg_t;

	typedef struct packed {
		logic              operation;
		logic [ADDR_W-1:0] start_lba;
		logic [31:0]       sector_count;
		logic              write_dir;
		logic [7:0]        final_status;
		logic              timed_out;
	} apcs_item_t;

	// what the emitter needs to produce all result beats of one item
	typedef struct packed {
		logic [2:0]        kind;
		logic              wide;
		logic              wr;
		logic              unit;
		logic [ADDR_W-1:0] lba;
		logic [15:0]       blk;
	} apcs_plan_t;

endpackage

`default_nettype wire

// ----- rtl/apcs_eval.sv -----
// ----------------------------------------------------------------------------
// apcs_eval
// request checking, chunk sizing and sequencer state, one item a cycle while plan_ready is high
// ----------------------------------------------------------------------------
`default_nettype none

module apcs_eval #(
	parameter int LBA_WIDTH = 48
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  apcs_pkg::apcs_cfg_t  cfg,
	input  wire                  item_valid,
	input  apcs_pkg::apcs_item_t item,
	input  wire                  plan_ready,
	output logic                 plan_load,
	output apcs_pkg::apcs_plan_t plan,
	output logic                 busy
);
	import apcs_pkg::*;

	logic                 busy_q;
	logic [LBA_WIDTH-1:0] lba_q;
	logic [31:0]          rem_q;
	logic [15:0]          chunk_q;
	logic                 wide_q;
	logic                 write_q;

	logic                 start;
	logic [LBA_WIDTH-1:0] lba_in;
	logic [SUM_W-1:0]     end_w;
	logic                 over_cap;
	logic                 over28;
	logic                 use48;
	logic                 reject;
	logic                 fail;
	logic [LBA_WIDTH-1:0] lba_adv;
	logic [31:0]          rem_adv;
	logic [31:0]          rem_sel;
	logic [LBA_WIDTH-1:0] lba_sel;
	logic                 wide_sel;
	logic [15:0]          max_blk;
	logic [15:0]          blk;
	logic                 take_start;
	logic                 advance;
	logic                 go_idle;

	assign start    = !item.operation;
	assign lba_in   = item.start_lba[LBA_WIDTH-1:0];
	assign end_w    = SUM_W'(lba_in) + SUM_W'(item.sector_count);
	assign over_cap = end_w > SUM_W'(cfg.capacity[LBA_WIDTH-1:0]);
	assign over28   = end_w > SUM_W'(LIMIT28);
	assign use48    = cfg.lba48_ok && (over28 || item.sector_count > 32'(MAX28));
	assign reject   = !cfg.is_disk || item.sector_count == 32'd0 || over_cap
		|| (!use48 && over28);
	assign fail     = item.timed_out || item.final_status == ST_FLOAT
		|| (item.final_status & (ST_ERR | ST_DF)) != 8'd0;

	assign lba_adv  = lba_q + LBA_WIDTH'(chunk_q);
	assign rem_adv  = rem_q - 32'(chunk_q);

	assign rem_sel  = start ? item.sector_count : rem_adv;
	assign lba_sel  = start ? lba_in : lba_adv;
	assign wide_sel = start ? use48 : wide_q;
	assign max_blk  = wide_sel ? MAX48 : MAX28;
	assign blk      = (rem_sel > 32'(max_blk)) ? max_blk : rem_sel[15:0];

	always_comb begin
		plan.kind  = KIND_BAD;
		plan.wide  = wide_sel;
		plan.wr    = start ? item.write_dir : write_q;
		plan.unit  = cfg.unit;
		plan.lba   = ADDR_W'(lba_sel);
		plan.blk   = blk;
		take_start = 1'b0;
		advance    = 1'b0;
		go_idle    = 1'b0;
		if (start) begin
			if (busy_q) begin
				plan.kind = KIND_BAD;
			end else if (reject) begin
				plan.kind = KIND_REJECT;
			end else begin
				plan.kind  = KIND_WRITE;
				take_start = 1'b1;
			end
		end else begin
			if (!busy_q) begin
				plan.kind = KIND_BAD;
			end else if (fail) begin
				plan.kind = KIND_FAIL;
				go_idle   = 1'b1;
			end else if (rem_adv == 32'd0) begin
				plan.kind = KIND_DONE;
				advance   = 1'b1;
				go_idle   = 1'b1;
			end else begin
				plan.kind = KIND_WRITE;
				advance   = 1'b1;
			end
		end
	end

	assign plan_load = item_valid && plan_ready;
	assign busy      = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			lba_q   <= '0;
			rem_q   <= '0;
			chunk_q <= '0;
			wide_q  <= 1'b0;
			write_q <= 1'b0;
		end else if (plan_load) begin
			if (take_start) begin
				busy_q  <= 1'b1;
				lba_q   <= lba_in;
				rem_q   <= item.sector_count;
				wide_q  <= use48;
				write_q <= item.write_dir;
				chunk_q <= blk;
			end
			if (advance) begin
				lba_q <= lba_adv;
				rem_q <= rem_adv;
				if (plan.kind == KIND_WRITE) begin
					chunk_q <= blk;
				end
			end
			if (go_idle) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/apcs_emit.sv -----
// ----------------------------------------------------------------------------
// apcs_emit
// holds one plan and sends its result beats through the output register
// ----------------------------------------------------------------------------
`default_nettype none

module apcs_emit (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  plan_load,
	input  apcs_pkg::apcs_plan_t plan,
	output logic                 plan_ready,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [15:0]          m_tdata,  // reg_select[3:0], reg_value[11:4], zero fill
	output logic [2:0]           m_tuser,  // kind[2:0]
	output logic                 m_tlast
);
	import apcs_pkg::*;

	apcs_plan_t  plan_q;
	logic        plan_valid_q;
	logic [3:0]  idx_q;
	logic        out_valid_q;
	logic [3:0]  out_reg_q;
	logic [7:0]  out_val_q;
	logic [2:0]  out_kind_q;
	logic        out_last_q;

	logic [3:0]  last_idx;
	logic        is_last;
	logic        out_free;
	logic [3:0]  beat_reg;
	logic [7:0]  beat_val;
	logic [7:0]  unit_bit;
	logic [7:0]  cmd;

	assign last_idx = (plan_q.kind != KIND_WRITE) ? 4'd0
		: (plan_q.wide ? LAST_BEAT48 : LAST_BEAT28);
	assign is_last    = idx_q == last_idx;
	assign out_free   = !out_valid_q || m_tready;
	assign plan_ready = !plan_valid_q || (out_free && is_last);

	assign unit_bit = plan_q.unit ? DRIVE_SLAVE : 8'd0;
	assign cmd      = plan_q.wide ? (plan_q.wr ? CMD_WR48 : CMD_RD48)
		: (plan_q.wr ? CMD_WR28 : CMD_RD28);

	always_comb begin
		beat_reg = REG_NONE;
		beat_val = 8'd0;
		if (plan_q.kind == KIND_WRITE) begin
			if (plan_q.wide) begin
				unique case (idx_q)
					4'd0:  begin beat_reg = REG_CTRL;  beat_val = CTRL_NO_IRQ; end
					4'd1:  begin beat_reg = REG_DRIVE; beat_val = DRIVE_LBA48 | unit_bit; end
					4'd2:  begin beat_reg = REG_COUNT; beat_val = plan_q.blk[15:8]; end
					4'd3:  begin beat_reg = REG_LBA0;  beat_val = plan_q.lba[31:24]; end
					4'd4:  begin beat_reg = REG_LBA1;  beat_val = plan_q.lba[39:32]; end
					4'd5:  begin beat_reg = REG_LBA2;  beat_val = plan_q.lba[47:40]; end
					4'd6:  begin beat_reg = REG_COUNT; beat_val = plan_q.blk[7:0]; end
					4'd7:  begin beat_reg = REG_LBA0;  beat_val = plan_q.lba[7:0]; end
					4'd8:  begin beat_reg = REG_LBA1;  beat_val = plan_q.lba[15:8]; end
					4'd9:  begin beat_reg = REG_LBA2;  beat_val = plan_q.lba[23:16]; end
					default: begin beat_reg = REG_CMD; beat_val = cmd; end
				endcase
			end else begin
				unique case (idx_q)
					4'd0: begin beat_reg = REG_CTRL; beat_val = CTRL_NO_IRQ; end
					4'd1: begin
						beat_reg = REG_DRIVE;
						beat_val = DRIVE_LBA28 | unit_bit | {4'd0, plan_q.lba[27:24]};
					end
					4'd2:    begin beat_reg = REG_COUNT; beat_val = plan_q.blk[7:0]; end
					4'd3:    begin beat_reg = REG_LBA0;  beat_val = plan_q.lba[7:0]; end
					4'd4:    begin beat_reg = REG_LBA1;  beat_val = plan_q.lba[15:8]; end
					4'd5:    begin beat_reg = REG_LBA2;  beat_val = plan_q.lba[23:16]; end
					default: begin beat_reg = REG_CMD;   beat_val = cmd; end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plan_valid_q <= 1'b0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (plan_valid_q && out_free) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? 4'd0 : idx_q + 4'd1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (plan_load) begin
				plan_valid_q <= 1'b1;
			end else if (plan_valid_q && out_free && is_last) begin
				plan_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (plan_load) begin
			plan_q <= plan;
		end
		if (plan_valid_q && out_free) begin
			out_reg_q  <= beat_reg;
			out_val_q  <= beat_val;
			out_kind_q <= plan_q.kind;
			out_last_q <= is_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_val_q, out_reg_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/ata_pio_command_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// ata_pio_command_sequencer_core
// host-side ata pio command issue for lba28 / lba48 task-file writes
//
//   port group   dir   content
//   s_*          in    start or chunk-finished items
//   m_*          out   register writes and status results, tlast on final
//   cfg_*        in    capacity, lba48 support, drive unit, disk present
//
// an accepted item passes the input and plan registers before its first beat
// reaches the output register; beats leave one per cycle while m_tready is high:
// 1 for a status result, 7 for an lba28 chunk, 11 for an lba48 chunk, and the
// next plan loads with the last beat of the previous one; reset clears state and
// configuration at once; m_tready low holds the output beat, s_tready drops while an
// item waits in the input register and the plan register still has beats to send
// ----------------------------------------------------------------------------
`default_nettype none
`include "ata_pio_command_sequencer_core_macros.svh"

module ata_pio_command_sequencer_core #(
	parameter int LBA_WIDTH = 48
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [95:0] s_tdata,  // start_lba[47:0], sector_count[79:48], write_dir[80],
	                              // final_status[88:81], timed_out[89], zero fill
	input  wire         s_tuser,  // operation[0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,  // reg_select[3:0], reg_value[11:4], zero fill
	output logic [2:0]  m_tuser,  // kind[2:0]
	output logic        m_tlast,
	input  wire         cfg_wen,
	input  wire  [1:0]  cfg_index,
	input  wire  [47:0] cfg_wdata
);
	import apcs_pkg::*;

	apcs_cfg_t  cfg_q;
	apcs_item_t item_s1;
	logic       valid_s1;
	apcs_plan_t plan;
	logic       plan_load;
	logic       plan_ready;
	logic       busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_CAPACITY: cfg_q.capacity <= cfg_wdata;
				CFG_LBA48:    cfg_q.lba48_ok <= cfg_wdata[0];
				CFG_DRIVE:    cfg_q.unit     <= cfg_wdata[0];
				CFG_IS_DISK:  cfg_q.is_disk  <= cfg_wdata[0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	assign s_tready = !valid_s1 || plan_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.operation    <= s_tuser;
			item_s1.start_lba    <= s_tdata[47:0];
			item_s1.sector_count <= s_tdata[79:48];
			item_s1.write_dir    <= s_tdata[80];
			item_s1.final_status <= s_tdata[88:81];
			item_s1.timed_out    <= s_tdata[89];
		end
	end

	apcs_eval #(
		.LBA_WIDTH(LBA_WIDTH)
	) u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item_valid(valid_s1),
		.item      (item_s1),
		.plan_ready(plan_ready),
		.plan_load (plan_load),
		.plan      (plan),
		.busy      (busy)
	);

	apcs_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.plan_load (plan_load),
		.plan      (plan),
		.plan_ready(plan_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// status results are single beats with an empty register field
	`APCS_ASSERT_NOW(a_status_single, m_tvalid && m_tuser != KIND_WRITE, m_tlast && m_tdata == 16'd0, "status result not a lone empty beat")

	// a chunk issue leaves the sequencer busy
	`APCS_ASSERT_NEXT(a_issue_busy, plan_load && plan.kind == KIND_WRITE, busy, "chunk issued while sequencer idle")

	// input is only held off while an item waits in the input register
	`APCS_ASSERT_NOW(a_stall_cause, !s_tready, valid_s1 && !plan_ready, "input stalled with no waiting item")

endmodule

`default_nettype wire
